FILE: sv/etx_pkg.sv
// Shared types and constants for the ETX link metric block.
// No dependencies; imported by every module of the block.
package etx_pkg;

    localparam int          METRIC_W       = 20;
    localparam int          RATIO_W        = 8;
    localparam int          PROD_W         = 2 * RATIO_W;
    localparam int          QUEUE_DEPTH    = 2;
    localparam logic [19:0] ETX_SCALE      = 20'd1000000;
    localparam logic [19:0] INVALID_RESET  = 20'd9999;

    typedef struct packed {
        logic [15:0] rate;
        logic [7:0]  power;
        logic [15:0] probe_size;
        logic [7:0]  fwd_ratio;
        logic [7:0]  rev_ratio;
        logic        last_entry;
    } t_in_beat;

    typedef struct packed {
        logic [19:0] metric;
        logic        link_invalid;
    } t_out_beat;

    // Kept entry of the link being scanned
    typedef struct packed {
        logic [15:0] rate;
        logic [7:0]  power;
        logic [15:0] probe_size;
        logic [7:0]  fwd_ratio;
        logic [7:0]  rev_ratio;
    } t_best;

    // Work handed from the front to the divider
    typedef struct packed {
        logic [7:0] fwd_ratio;
        logic [7:0] rev_ratio;
    } t_job;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

FILE: sv/etx_link_metric.sv
// Top level of the ETX link metric block: config register, front end, queue, divider.
// Depends on etx_pkg, etx_front, etx_queue, etx_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_beat) takes one probe entry
//   per beat; all entries of one link are sent in order, the last one with
//   last_entry set. Each entry is weighed in its accept cycle, so entries may
//   arrive back to back. The last entry queues a divide job.
//   Output channel (o_out_valid / i_out_stall / o_out_beat) delivers one beat
//   per link: metric = 1000000 / (fwd * rev) of the kept entry, or the
//   invalid metric with link_invalid set when a ratio is zero.
//   From the last entry to the result, a valid link passes the queue, the
//   product load, 20 radix-2 divide steps and the output load; an invalid
//   link skips the divide steps. The one-bit-per-cycle divider works on one
//   link at a time; a two-entry job queue lets the front keep taking entries
//   while the divider works.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the invalid
//   metric; it is always ready. Write it only while the block is idle.
//   Reset clears the kept entry, the queue and the output; the invalid metric
//   returns to 9999. A stalled receiver holds the output beat; once the queue
//   fills, o_in_stall rises.
module etx_link_metric import etx_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_beat            i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_beat           o_out_beat,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [METRIC_W-1:0] i_cfg_data
);

    logic [METRIC_W-1:0] r_invalid_metric;
    t_q_status           q_status;
    logic                push;
    logic                pop;
    t_job                push_job;
    t_job                pop_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invalid_metric <= INVALID_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_invalid_metric <= i_cfg_data;
        end
    end

    etx_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_beat  (i_in_beat),
        .i_q_status (q_status),
        .o_push     (push),
        .o_job      (push_job)
    );

    etx_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (pop_job),
        .o_status (q_status)
    );

    etx_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job_valid      (!q_status.empty),
        .o_pop            (pop),
        .i_job            (pop_job),
        .i_invalid_metric (r_invalid_metric),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_beat       (o_out_beat)
    );

endmodule

FILE: sv/etx_front.sv
// Front end: accepts probe entries, keeps the best one, queues a job on the last entry.
// Depends on etx_pkg.
module etx_front import etx_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    input  t_q_status i_q_status,
    output logic      o_push,
    output t_job      o_job
);

    logic  r_have;
    t_best r_best;
    logic  accept;
    logic  beats;
    logic  take;

    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        beats = (i_in_beat.rate < r_best.rate) ||
                ((i_in_beat.rate == r_best.rate) &&
                 ((i_in_beat.power > r_best.power) ||
                  ((i_in_beat.power == r_best.power) &&
                   (i_in_beat.probe_size < r_best.probe_size))));
        take  = !r_have || beats;
    end

    assign o_push          = accept && i_in_beat.last_entry;
    assign o_job.fwd_ratio = take ? i_in_beat.fwd_ratio : r_best.fwd_ratio;
    assign o_job.rev_ratio = take ? i_in_beat.rev_ratio : r_best.rev_ratio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_best <= '0;
        end else if (accept) begin
            // last entry closes the link: start the next one empty
            r_have <= !i_in_beat.last_entry;
            if (take) begin
                r_best.rate       <= i_in_beat.rate;
                r_best.power      <= i_in_beat.power;
                r_best.probe_size <= i_in_beat.probe_size;
                r_best.fwd_ratio  <= i_in_beat.fwd_ratio;
                r_best.rev_ratio  <= i_in_beat.rev_ratio;
            end
        end
    end

endmodule

FILE: sv/etx_queue.sv
// Short job queue between the front end and the divider.
// Depends on etx_pkg.
module etx_queue import etx_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_job      i_job,
    input  logic      i_pop,
    output t_job      o_job,
    output t_q_status o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_job          = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: sv/etx_back.sv
// Back end: radix-2 restoring divide of the scale by fwd*rev, one quotient bit a cycle.
// Depends on etx_pkg.
module etx_back import etx_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    output logic                o_pop,
    input  t_job                i_job,
    input  logic [METRIC_W-1:0] i_invalid_metric,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_beat           o_out_beat
);

    localparam int NW = $clog2(METRIC_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_HOLD
    } t_state;

    t_state              r_state;
    logic [PROD_W-1:0]   r_dvs;
    logic [PROD_W-1:0]   r_rem;
    logic [METRIC_W-1:0] r_quo;
    logic                r_bad;
    logic [NW-1:0]       r_step;
    logic                r_out_valid;
    t_out_beat           r_out;
    logic [PROD_W:0]     trial;
    logic                fits;
    logic                out_free;
    logic                load_out;
    logic                zero_ratio;
    logic [PROD_W-1:0]   product;

    assign o_pop       = (r_state == S_IDLE) && i_job_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign load_out    = (r_state == S_HOLD) && out_free;
    assign zero_ratio  = (i_job.fwd_ratio == '0) || (i_job.rev_ratio == '0);
    assign product     = PROD_W'({{RATIO_W{1'b0}}, i_job.fwd_ratio} *
                                 {{RATIO_W{1'b0}}, i_job.rev_ratio});
    assign trial       = {r_rem, r_quo[METRIC_W-1]};
    assign fits        = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            // load a new beat, or drop the current one once it is taken
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_dvs  <= product;
                        r_rem  <= '0;
                        r_step <= '0;
                        r_bad  <= zero_ratio;
                        if (zero_ratio) begin
                            r_quo   <= i_invalid_metric;
                            r_state <= S_HOLD;
                        end else begin
                            r_quo   <= ETX_SCALE;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    // shift in the next dividend bit, subtract when it fits
                    r_rem  <= fits ? PROD_W'(trial - {1'b0, r_dvs}) : trial[PROD_W-1:0];
                    r_quo  <= {r_quo[METRIC_W-2:0], fits};
                    r_step <= r_step + 1'b1;
                    if (r_step == NW'(METRIC_W - 1)) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    // hold the result until the output register frees up
                    if (out_free) begin
                        r_out.metric       <= r_quo;
                        r_out.link_invalid <= r_bad;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: sv/etx_link_metric_checker.sv
// Port-level checks for etx_link_metric, attached by bind.
// Depends on etx_pkg and etx_link_metric.
module etx_link_metric_checker import etx_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_beat o_out_beat
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("output beat changed while stalled");

    // a computed metric lies between 15 and the scale
    a_metric_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_beat.link_invalid |->
            (o_out_beat.metric >= 20'd15) && (o_out_beat.metric <= ETX_SCALE))
        else $error("computed metric out of range");

    // reset drops the output
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind etx_link_metric etx_link_metric_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_beat  (o_out_beat)
);
